FILE: rtl/line_ending_scanner_defines.svh
// ----------------------------------------------------------------------------
// line_ending_scanner_defines.svh
// Assertion macros shared by the line ending scanner RTL.
// ----------------------------------------------------------------------------
`ifndef LINE_ENDING_SCANNER_DEFINES_SVH
`define LINE_ENDING_SCANNER_DEFINES_SVH

// Clocked assertion, switched off while reset is held
`define LES_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Clocked assertion that also watches the reset itself
`define LES_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: rtl/les_pkg.sv
// ----------------------------------------------------------------------------
// les_pkg
// Constants and types for the line ending scanner.
// ----------------------------------------------------------------------------
package les_pkg;

    // Default width of the byte position counter
    localparam int unsigned POS_WIDTH_DEF = 32;

    // Characters that end a line
    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_CR = 8'd13;

    // Terminator size codes
    localparam logic [1:0] TERM_NONE   = 2'd0;
    localparam logic [1:0] TERM_SINGLE = 2'd1;
    localparam logic [1:0] TERM_CRLF   = 2'd2;

    // Ending kinds seen, one bit each
    localparam logic [2:0] KIND_LF   = 3'b001;
    localparam logic [2:0] KIND_CRLF = 3'b010;
    localparam logic [2:0] KIND_CR   = 3'b100;

    // Dominant ending codes
    localparam logic [1:0] DOM_LF   = 2'd0;
    localparam logic [1:0] DOM_CRLF = 2'd1;
    localparam logic [1:0] DOM_CR   = 2'd2;

    // Result queue sizing: an end beat yields up to three records
    localparam int unsigned MAX_RESULTS = 3;
    localparam int unsigned QDEPTH      = 4;

    // One line record as queued for output
    typedef struct packed {
        logic        endings_mixed;
        logic [1:0]  dominant_ending;
        logic        document_last;
        logic        run_last;
        logic [1:0]  terminator_size;
        logic [31:0] line_length;
        logic [31:0] line_start;
    } rec_t;

endpackage

FILE: rtl/line_ending_scanner.sv
// ----------------------------------------------------------------------------
// line_ending_scanner
// Splits a byte stream into line records with LF, CR and CRLF terminators.
// ----------------------------------------------------------------------------
// The scanner takes one beat per cycle and produces line records of start
// offset, length and terminator size. A beat carrying a byte yields at most
// one record, so a plain text stream runs at one byte per clock while the
// receiver keeps up, each record entering the result queue as its beat is
// accepted. A beat with s_tlast set ends the document and yields up to three
// records (a line ended by its own byte, a held CR line and the final line,
// which carries the dominant ending and the mixed flag); these drain one per
// cycle while m_tready is high, from a four-entry result queue. s_tready is
// high while the queue holds at most one record, so the input is paused
// after an end beat or while the receiver stalls. A CR line is held in the
// scan state until the next byte shows whether it is part of a CRLF.
`include "line_ending_scanner_defines.svh"

module line_ending_scanner #(
    parameter int unsigned POS_WIDTH = les_pkg::POS_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: base_offset
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    // Input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] byte_present
    input  logic        s_tlast,   // end_of_document
    // Line records
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [31:0] line_start, [63:32] line_length,
                                   // [65:64] terminator_size, [71:66] zero
    output logic [3:0]  m_tuser,   // [0] document_last, [2:1] dominant_ending,
                                   // [3] endings_mixed
    output logic        m_tlast    // run_last
);

    localparam int unsigned EXT_W  = (POS_WIDTH > 32) ? POS_WIDTH : 32;
    localparam int unsigned QDEPTH = les_pkg::QDEPTH;
    localparam int unsigned PTR_W  = $clog2(QDEPTH);
    localparam int unsigned CNT_W  = $clog2(QDEPTH + 1);

    // Reduce a position-wide value to 32 bits
    function automatic logic [31:0] to32(input logic [POS_WIDTH-1:0] v);
        logic [EXT_W-1:0] w;
        w = EXT_W'(v);
        return w[31:0];
    endfunction

    // Scan state
    logic [31:0]          base_reg;
    logic [POS_WIDTH-1:0] pos_reg, pos_next;
    logic [POS_WIDTH-1:0] lb_reg, lb_next;
    logic                 cr_pend_reg, cr_pend_next;
    logic [POS_WIDTH-1:0] pend_start_reg, pend_start_next;
    logic [POS_WIDTH-1:0] pend_len_reg, pend_len_next;
    logic [2:0]           kinds_reg, kinds_next;

    // Result queue
    les_pkg::rec_t        q_reg [QDEPTH];
    les_pkg::rec_t        q_next [QDEPTH];
    logic [QDEPTH-1:0]    q_we;
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    // Step logic
    logic                 s_fire, m_fire;
    logic                 byte_present, eod;
    logic                 b_lf, b_cr, pos_max;
    logic [POS_WIDTH-1:0] nxt;
    logic [POS_WIDTH-1:0] pos1, lb1, ps1, pl1;
    logic                 cr1;
    logic [2:0]           kinds1, kinds2;
    logic                 a_vld, b_vld;
    les_pkg::rec_t        a_rec, b_rec, c_rec;
    les_pkg::rec_t        slot [QDEPTH];
    logic [1:0]           n_rec;
    logic [CNT_W-1:0]     push_n;
    logic [PTR_W-1:0]     off [QDEPTH];

    assign s_fire       = s_tvalid && s_tready;
    assign m_fire       = m_tvalid && m_tready;
    assign byte_present = s_tuser[0];
    assign eod          = s_tlast;
    assign s_tready     = (count_reg <= CNT_W'(QDEPTH - les_pkg::MAX_RESULTS));

    // Scan one beat: byte first, then document end
    always_comb begin
        pos_max = (pos_reg == '1);
        nxt     = pos_max ? pos_reg : pos_reg + 1'b1;
        b_lf    = (s_tdata == les_pkg::CH_LF);
        b_cr    = (s_tdata == les_pkg::CH_CR);

        pos1   = pos_reg;
        lb1    = lb_reg;
        ps1    = pend_start_reg;
        pl1    = pend_len_reg;
        cr1    = cr_pend_reg;
        kinds1 = kinds_reg;
        a_vld  = 1'b0;
        a_rec  = '0;

        if (byte_present) begin
            pos1 = nxt;
            // Resolve a held CR line
            if (cr_pend_reg) begin
                a_vld            = 1'b1;
                cr1              = 1'b0;
                a_rec.line_start = base_reg + to32(pend_start_reg);
                if (b_lf) begin
                    a_rec.line_length     = to32(pend_len_reg + POS_WIDTH'(!pos_max));
                    a_rec.terminator_size = les_pkg::TERM_CRLF;
                    kinds1                = kinds1 | les_pkg::KIND_CRLF;
                    lb1                   = nxt;
                end else begin
                    a_rec.line_length     = to32(pend_len_reg);
                    a_rec.terminator_size = les_pkg::TERM_SINGLE;
                    kinds1                = kinds1 | les_pkg::KIND_CR;
                end
            end
            // Fresh terminator
            if (!(cr_pend_reg && b_lf)) begin
                if (b_lf) begin
                    a_vld                 = 1'b1;
                    a_rec.line_start      = base_reg + to32(lb_reg);
                    a_rec.line_length     = to32(nxt - lb_reg);
                    a_rec.terminator_size = les_pkg::TERM_SINGLE;
                    kinds1                = kinds1 | les_pkg::KIND_LF;
                    lb1                   = nxt;
                end else if (b_cr) begin
                    ps1 = lb_reg;
                    pl1 = nxt - lb_reg;
                    cr1 = 1'b1;
                    lb1 = nxt;
                end
            end
        end
        a_rec.run_last = !eod;

        // Flush a held CR line at document end
        b_vld                 = eod && cr1;
        b_rec                 = '0;
        b_rec.line_start      = base_reg + to32(ps1);
        b_rec.line_length     = to32(pl1);
        b_rec.terminator_size = les_pkg::TERM_SINGLE;
        kinds2                = b_vld ? (kinds1 | les_pkg::KIND_CR) : kinds1;

        // Final line with document summary
        c_rec                 = '0;
        c_rec.line_start      = base_reg + to32(lb1);
        c_rec.line_length     = to32(pos1 - lb1);
        c_rec.terminator_size = les_pkg::TERM_NONE;
        c_rec.run_last        = 1'b1;
        c_rec.document_last   = 1'b1;
        c_rec.endings_mixed   = ((kinds2 & (kinds2 - 3'd1)) != 3'd0);
        priority if ((kinds2 & les_pkg::KIND_CRLF) != 3'd0) begin
            c_rec.dominant_ending = les_pkg::DOM_CRLF;
        end else if ((kinds2 & les_pkg::KIND_LF) != 3'd0) begin
            c_rec.dominant_ending = les_pkg::DOM_LF;
        end else if ((kinds2 & les_pkg::KIND_CR) != 3'd0) begin
            c_rec.dominant_ending = les_pkg::DOM_CR;
        end else begin
            c_rec.dominant_ending = les_pkg::DOM_LF;
        end

        // Next scan state: start over after document end
        if (eod) begin
            pos_next        = '0;
            lb_next         = '0;
            cr_pend_next    = 1'b0;
            pend_start_next = '0;
            pend_len_next   = '0;
            kinds_next      = '0;
        end else begin
            pos_next        = pos1;
            lb_next         = lb1;
            cr_pend_next    = cr1;
            pend_start_next = ps1;
            pend_len_next   = pl1;
            kinds_next      = kinds1;
        end
    end

    // Pack records into consecutive slots
    always_comb begin
        n_rec   = 2'(a_vld) + 2'(b_vld) + 2'(eod);
        slot[0] = a_vld ? a_rec : (b_vld ? b_rec : c_rec);
        slot[1] = a_vld ? (b_vld ? b_rec : c_rec) : c_rec;
        slot[2] = c_rec;
        slot[3] = '0;
        for (int i = 3; i < QDEPTH; i++) begin
            slot[i] = '0;
        end
        push_n = s_fire ? CNT_W'(n_rec) : '0;
    end

    // Queue write enables and pointer updates
    always_comb begin
        for (int i = 0; i < QDEPTH; i++) begin
            off[i]    = PTR_W'(i) - wr_ptr_reg;
            q_we[i]   = (CNT_W'(off[i]) < push_n);
            q_next[i] = slot[off[i]];
        end
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + PTR_W'(m_fire);
        count_next  = count_reg + push_n - CNT_W'(m_fire);
    end

    // Hold configuration, scan state and queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg       <= '0;
            pos_reg        <= '0;
            lb_reg         <= '0;
            cr_pend_reg    <= 1'b0;
            pend_start_reg <= '0;
            pend_len_reg   <= '0;
            kinds_reg      <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end else begin
            if (cfg_we) begin
                base_reg <= cfg_wdata;
            end
            if (s_fire) begin
                pos_reg        <= pos_next;
                lb_reg         <= lb_next;
                cr_pend_reg    <= cr_pend_next;
                pend_start_reg <= pend_start_next;
                pend_len_reg   <= pend_len_next;
                kinds_reg      <= kinds_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store queued records
    always_ff @(posedge aclk) begin
        for (int i = 0; i < QDEPTH; i++) begin
            if (q_we[i]) begin
                q_reg[i] <= q_next[i];
            end
        end
    end

    // Drive the head record
    les_pkg::rec_t head;
    assign head     = q_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {6'd0, head.terminator_size, head.line_length, head.line_start};
    assign m_tuser  = {head.endings_mixed, head.dominant_ending, head.document_last};
    assign m_tlast  = head.run_last;

    // Checks
    `LES_ASSERT_RST(a_rst_empty, !aresetn |=> (count_reg == '0), "queue not empty after reset")
    `LES_ASSERT(a_cnt_bound, count_reg <= CNT_W'(QDEPTH), "result queue overflow")
    `LES_ASSERT(a_eod_clear, (s_fire && s_tlast) |=> (!cr_pend_reg && kinds_reg == '0 && pos_reg == '0), "scan state not cleared at document end")
    `LES_ASSERT(a_eod_out, (s_fire && s_tlast) |=> m_tvalid, "no record after document end")
    `LES_ASSERT(a_doc_last, (m_tvalid && m_tuser[0]) |-> m_tlast, "final record not last of its beat")

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the line ending scanner.
// ----------------------------------------------------------------------------
// Text beats go in on the s_ stream and line records are compared with a
// behavioural scanner kept in step with every accepted beat. The scanner is
// built with an 8-bit position counter. A directed table opens
// the run and covers empty documents, LF, CR, CRLF, held CR lines, ignored
// bytes, end beats with and without a byte, and base offsets at the top of
// the range. Random documents follow, with the base offset rewritten between
// them. The sender runs in bursts and the receiver stalls in changing
// patterns.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int            POS_W        = 8;
    localparam logic [63:0]   POS_LIMIT    = (64'd1 << POS_W) - 64'd1;
    localparam int unsigned   CYCLE_LIMIT  = 200000;
    localparam int            RANDOM_BEATS = 80;
    localparam int            MAX_FAULT_LINES = 50;
    localparam les_pkg::rec_t NO_LINE      = '0;

    typedef enum logic {ROW_BEAT, ROW_BASE} row_kind_t;
    typedef enum logic [2:0] {DOC_LF, DOC_CRLF, DOC_CR, DOC_MIXED, DOC_BARE} doc_style_t;

    // One row of the directed table; want is used only where typed is set
    typedef struct packed {
        row_kind_t     kind;
        logic [31:0]   base;
        logic [7:0]    data;
        logic          present;
        logic          doc_end;
        logic          typed;
        les_pkg::rec_t want;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic [0:0]  s_tuser;   // [0] byte_present
    logic        s_tlast;   // end_of_document
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // [31:0] line_start, [63:32] line_length,
                            // [65:64] terminator_size, [71:66] zero
    logic [3:0]  m_tuser;   // [0] document_last, [2:1] dominant_ending,
                            // [3] endings_mixed
    logic        m_tlast;   // run_last

    // Scanner state as seen by the bench
    logic [31:0] base_off   = '0;
    logic [63:0] scan_pos   = '0;
    logic [63:0] line_beg   = '0;
    logic [63:0] held_start = '0;
    logic [63:0] held_len   = '0;
    bit          held_cr    = 1'b0;
    logic [2:0]  kinds_seen = '0;

    les_pkg::rec_t fresh_recs[$];
    les_pkg::rec_t awaited_lines[$];

    int unsigned cycle_count = 0;
    int          faults      = 0;
    int          beats       = 0;
    int          docs        = 0;
    int          lines_seen  = 0;
    int          base_writes = 0;
    int          burst_left  = 0;

    logic [5:0]  stall_tick;
    logic [1:0]  stall_mode;

    line_ending_scanner #(
        .POS_WIDTH (POS_W)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Give up on a hung run
    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic les_pkg::rec_t line_rec(input logic [31:0] start,
                                               input logic [31:0] len,
                                               input logic [1:0] term, input logic run,
                                               input logic doc, input logic [1:0] dom,
                                               input logic mixed);
        les_pkg::rec_t r;
        r.line_start      = start;
        r.line_length     = len;
        r.terminator_size = term;
        r.run_last        = run;
        r.document_last   = doc;
        r.dominant_ending = dom;
        r.endings_mixed   = mixed;
        return r;
    endfunction

    function automatic void add_line(input logic [63:0] start, input logic [63:0] len,
                                     input logic [1:0] term);
        fresh_recs = {fresh_recs, line_rec(base_off + start[31:0], len[31:0], term,
                                           1'b0, 1'b0, les_pkg::DOM_LF, 1'b0)};
    endfunction

    // Advance the scanner by one accepted beat, leaving its records in fresh_recs
    function automatic void scan_item(input logic [7:0] d, input bit present,
                                      input bit doc_end);
        logic [63:0] nxt;
        logic [63:0] tail_len;
        logic [1:0]  dom;
        logic        mixed;
        bit          joined;
        int          last;
        fresh_recs.delete();
        if (present) begin
            nxt    = (scan_pos < POS_LIMIT) ? scan_pos + 64'd1 : scan_pos;
            joined = 1'b0;
            // A held CR either merges with this LF or goes out on its own
            if (held_cr) begin
                held_cr = 1'b0;
                if (d == les_pkg::CH_LF) begin
                    add_line(held_start, held_len + (nxt - scan_pos), les_pkg::TERM_CRLF);
                    kinds_seen |= les_pkg::KIND_CRLF;
                    line_beg = nxt;
                    joined   = 1'b1;
                end else begin
                    add_line(held_start, held_len, les_pkg::TERM_SINGLE);
                    kinds_seen |= les_pkg::KIND_CR;
                end
            end
            if (!joined && d == les_pkg::CH_LF) begin
                add_line(line_beg, nxt - line_beg, les_pkg::TERM_SINGLE);
                kinds_seen |= les_pkg::KIND_LF;
                line_beg = nxt;
            end else if (!joined && d == les_pkg::CH_CR) begin
                held_start = line_beg;
                held_len   = nxt - line_beg;
                held_cr    = 1'b1;
                line_beg   = nxt;
            end
            scan_pos = nxt;
        end
        if (doc_end) begin
            if (held_cr) begin
                add_line(held_start, held_len, les_pkg::TERM_SINGLE);
                kinds_seen |= les_pkg::KIND_CR;
            end
            if ((kinds_seen & les_pkg::KIND_CRLF) != 0)
                dom = les_pkg::DOM_CRLF;
            else if ((kinds_seen & les_pkg::KIND_LF) != 0)
                dom = les_pkg::DOM_LF;
            else if ((kinds_seen & les_pkg::KIND_CR) != 0)
                dom = les_pkg::DOM_CR;
            else
                dom = les_pkg::DOM_LF;
            mixed    = ((kinds_seen & (kinds_seen - 3'd1)) != 0);
            tail_len = scan_pos - line_beg;
            fresh_recs = {fresh_recs, line_rec(base_off + line_beg[31:0], tail_len[31:0],
                                               les_pkg::TERM_NONE, 1'b0, 1'b1, dom,
                                               mixed)};
            // Start the next document from scratch
            scan_pos   = '0;
            line_beg   = '0;
            held_cr    = 1'b0;
            held_start = '0;
            held_len   = '0;
            kinds_seen = '0;
        end
        if (fresh_recs.size() != 0) begin
            last = fresh_recs.size() - 1;
            fresh_recs[last].run_last = 1'b1;
        end
    endfunction

    task automatic note_fault(input string msg);
        if (faults < MAX_FAULT_LINES)
            $display("ERROR at %0t: %s", $realtime, msg);
        faults++;
    endtask

    // Drive one beat, holding it until taken; the sender idles between bursts
    task automatic send_beat(input logic [7:0] d, input bit present, input bit doc_end,
                             input bit typed, input les_pkg::rec_t want);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= present;
        s_tlast  <= doc_end;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        scan_item(d, present, doc_end);
        if (typed)
            awaited_lines = {awaited_lines, want};
        else
            awaited_lines = {awaited_lines, fresh_recs};
        if (present || doc_end) beats++;
        if (doc_end) docs++;
    endtask

    // Let the block drain, then rewrite the base offset
    task automatic set_base(input logic [31:0] value);
        s_tvalid  <= 1'b0;
        burst_left = 0;
        while (awaited_lines.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        base_off   = value;
        base_writes++;
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == les_pkg::CH_LF || b == les_pkg::CH_CR) b ^= 8'h80;
        return b;
    endfunction

    // Send a text byte, now and then after an empty beat
    task automatic send_char(input logic [7:0] d);
        if ($urandom_range(0, 9) == 0)
            send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, NO_LINE);
        send_beat(d, 1'b1, 1'b0, 1'b0, NO_LINE);
    endtask

    task automatic send_document(input doc_style_t style);
        logic [7:0] last_byte;
        repeat ($urandom_range(0, 4)) begin
            repeat ($urandom_range(0, 5)) send_char(text_byte());
            case (style)
                DOC_LF: send_char(les_pkg::CH_LF);
                DOC_CRLF: begin
                    // Mostly proper pairs, now and then a lone CR
                    send_char(les_pkg::CH_CR);
                    if ($urandom_range(0, 5) != 0) send_char(les_pkg::CH_LF);
                end
                DOC_CR: send_char(les_pkg::CH_CR);
                DOC_MIXED: begin
                    case ($urandom_range(0, 2))
                        0: send_char(les_pkg::CH_LF);
                        1: send_char(les_pkg::CH_CR);
                        default: begin
                            send_char(les_pkg::CH_CR);
                            send_char(les_pkg::CH_LF);
                        end
                    endcase
                end
                default: ;
            endcase
        end
        if (style == DOC_BARE || $urandom_range(0, 1) == 1)
            repeat ($urandom_range(0, 4)) send_char(text_byte());
        case ($urandom_range(0, 3))
            0: last_byte = les_pkg::CH_LF;
            1: last_byte = les_pkg::CH_CR;
            default: last_byte = text_byte();
        endcase
        send_beat(last_byte, 1'($urandom_range(0, 1)), 1'b1, 1'b0, NO_LINE);
    endtask

    // Receiver: the stall pattern changes each time the 6-bit stall_tick wraps
    initial begin
        m_tready   <= 1'b0;
        stall_tick <= '0;
        stall_mode <= '0;
    end

    always @(posedge aclk) begin
        stall_tick <= stall_tick + 6'd1;
        if (stall_tick == 6'd0) stall_mode <= 2'($urandom_range(0, 3));
        case (stall_mode)
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= ($urandom_range(0, 3) != 0);
            2'd2: m_tready <= (stall_tick[1:0] == 2'd0);
            default: m_tready <= 1'($urandom_range(0, 1));
        endcase
    end

    // Compare every record taken from the block with the oldest expected one
    always @(posedge aclk) begin : line_check
        les_pkg::rec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_lines.size() == 0) begin
                note_fault($sformatf("unexpected record, start %h length %h",
                                     m_tdata[31:0], m_tdata[63:32]));
            end else begin
                want = awaited_lines.pop_front();
                if (m_tdata[31:0] !== want.line_start)
                    note_fault($sformatf("record %0d: start %h, expected %h",
                                         lines_seen, m_tdata[31:0], want.line_start));
                if (m_tdata[63:32] !== want.line_length)
                    note_fault($sformatf("record %0d: length %h, expected %h",
                                         lines_seen, m_tdata[63:32], want.line_length));
                if (m_tdata[65:64] !== want.terminator_size)
                    note_fault($sformatf("record %0d: terminator %0d, expected %0d",
                                         lines_seen, m_tdata[65:64], want.terminator_size));
                if (m_tdata[71:66] !== 6'd0)
                    note_fault($sformatf("record %0d: padding %h not zero",
                                         lines_seen, m_tdata[71:66]));
                if (m_tlast !== want.run_last)
                    note_fault($sformatf("record %0d: run_last %b, expected %b",
                                         lines_seen, m_tlast, want.run_last));
                if (m_tuser[0] !== want.document_last)
                    note_fault($sformatf("record %0d: document_last %b, expected %b",
                                         lines_seen, m_tuser[0], want.document_last));
                if (m_tuser[2:1] !== want.dominant_ending)
                    note_fault($sformatf("record %0d: dominant ending %0d, expected %0d",
                                         lines_seen, m_tuser[2:1], want.dominant_ending));
                if (m_tuser[3] !== want.endings_mixed)
                    note_fault($sformatf("record %0d: mixed %b, expected %b",
                                         lines_seen, m_tuser[3], want.endings_mixed));
            end
            lines_seen++;
        end
    end

    function automatic dir_row_t row(input row_kind_t kind, input logic [31:0] base,
                                     input logic [7:0] d, input logic present,
                                     input logic doc_end, input logic typed,
                                     input les_pkg::rec_t want);
        dir_row_t r;
        r.kind    = kind;
        r.base    = base;
        r.data    = d;
        r.present = present;
        r.doc_end = doc_end;
        r.typed   = typed;
        r.want    = want;
        return r;
    endfunction

    initial begin : stimulus
        dir_row_t    rows[$];
        int          dir_beats;
        logic [31:0] v;

        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        s_tlast   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        aresetn   <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn   <= 1'b1;

        // Directed table: base offset is zero out of reset
        rows = {rows, row(ROW_BEAT, '0, 8'hFF, 1'b0, 1'b0, 1'b0, NO_LINE)};  // empty beat
        rows = {rows, row(ROW_BEAT, '0, les_pkg::CH_LF, 1'b0, 1'b1, 1'b1,    // empty document
                          line_rec(32'd0, 32'd0, les_pkg::TERM_NONE, 1'b1, 1'b1,
                                   les_pkg::DOM_LF, 1'b0))};
        rows = {rows, row(ROW_BEAT, '0, 8'h41, 1'b1, 1'b0, 1'b0, NO_LINE)};
        rows = {rows, row(ROW_BEAT, '0, les_pkg::CH_LF, 1'b1, 1'b0, 1'b1,
                          line_rec(32'd0, 32'd2, les_pkg::TERM_SINGLE, 1'b1, 1'b0,
                                   les_pkg::DOM_LF, 1'b0))};
        rows = {rows, row(ROW_BEAT, '0, les_pkg::CH_CR, 1'b1, 1'b0, 1'b0, NO_LINE)};
        rows = {rows, row(ROW_BEAT, '0, les_pkg::CH_LF, 1'b1, 1'b0, 1'b1,
                          line_rec(32'd2, 32'd2, les_pkg::TERM_CRLF, 1'b1, 1'b0,
                                   les_pkg::DOM_LF, 1'b0))};
        rows = {rows, row(ROW_BEAT, '0, les_pkg::CH_CR, 1'b1, 1'b0, 1'b0, NO_LINE)};
        rows = {rows, row(ROW_BEAT, '0, les_pkg::CH_CR, 1'b1, 1'b0, 1'b1,    // CR releases held CR
                          line_rec(32'd4, 32'd1, les_pkg::TERM_SINGLE, 1'b1, 1'b0,
                                   les_pkg::DOM_LF, 1'b0))};
        rows = {rows, row(ROW_BEAT, '0, 8'h00, 1'b1, 1'b0, 1'b1,
                          line_rec(32'd5, 32'd1, les_pkg::TERM_SINGLE, 1'b1, 1'b0,
                                   les_pkg::DOM_LF, 1'b0))};
        rows = {rows, row(ROW_BEAT, '0, les_pkg::CH_CR, 1'b0, 1'b0, 1'b0,    // CR not present
                          NO_LINE)};
        rows = {rows, row(ROW_BEAT, '0, 8'hFF, 1'b1, 1'b0, 1'b0, NO_LINE)};
        rows = {rows, row(ROW_BEAT, '0, les_pkg::CH_CR, 1'b1, 1'b1, 1'b0,    // CR on the end beat
                          NO_LINE)};
        rows = {rows, row(ROW_BASE, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, 1'b0, NO_LINE)};
        rows = {rows, row(ROW_BEAT, '0, les_pkg::CH_LF, 1'b1, 1'b1, 1'b0,    // start wraps
                          NO_LINE)};
        rows = {rows, row(ROW_BEAT, '0, les_pkg::CH_CR, 1'b1, 1'b0, 1'b0, NO_LINE)};
        rows = {rows, row(ROW_BEAT, '0, 8'hFF, 1'b0, 1'b1, 1'b0, NO_LINE)};  // bare end flushes CR
        rows = {rows, row(ROW_BASE, 32'h8000_0000, '0, 1'b0, 1'b0, 1'b0, NO_LINE)};
        rows = {rows, row(ROW_BEAT, '0, 8'h7F, 1'b1, 1'b0, 1'b0, NO_LINE)};
        rows = {rows, row(ROW_BEAT, '0, 8'h80, 1'b1, 1'b1, 1'b1,              // no terminator at all
                          line_rec(32'h8000_0000, 32'd2, les_pkg::TERM_NONE, 1'b1, 1'b1,
                                   les_pkg::DOM_LF, 1'b0))};
        rows = {rows, row(ROW_BEAT, '0, les_pkg::CH_CR, 1'b1, 1'b0, 1'b0, NO_LINE)};
        rows = {rows, row(ROW_BEAT, '0, les_pkg::CH_CR, 1'b1, 1'b0, 1'b0, NO_LINE)};
        rows = {rows, row(ROW_BEAT, '0, les_pkg::CH_LF, 1'b1, 1'b0, 1'b0, NO_LINE)};
        rows = {rows, row(ROW_BEAT, '0, les_pkg::CH_LF, 1'b1, 1'b0, 1'b0, NO_LINE)};
        rows = {rows, row(ROW_BEAT, '0, 8'h55, 1'b1, 1'b1, 1'b0, NO_LINE)};

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_BASE)
                set_base(rows[i].base);
            else
                send_beat(rows[i].data, rows[i].present, rows[i].doc_end,
                          rows[i].typed, rows[i].want);
        end
        dir_beats = beats;

        // Random documents
        while (beats < dir_beats + RANDOM_BEATS) begin
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 3))
                    0: v = 32'd0;
                    1: v = 32'hFFFF_FFFF;
                    2: v = 32'hFFFF_FFFF - $urandom_range(0, 40);
                    default: v = $urandom;
                endcase
                set_base(v);
            end
            send_document(doc_style_t'($urandom_range(0, 4)));
        end

        // Drain and let the block settle
        s_tvalid <= 1'b0;
        while (awaited_lines.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Scanned %0d beats in %0d documents with a %0d-bit position, %0d records.",
                 beats, docs, POS_W, lines_seen);
        $display("Base offset rewritten %0d times between documents.", base_writes);
        if (faults == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
